// ----- hdl/gbc_pkg.sv -----
// Package for the Givens boundary cell: widths, fixed-point constants,
// sequencer state type and the compare/subtract unit result type.
// No dependencies.
package gbc_pkg;

    localparam int X_W       = 16;   // signed Q8.8 sample
    localparam int MAG_W     = 16;   // |x|, up to 32768
    localparam int DIAG_W    = 18;   // unsigned Q10.8 diagonal
    localparam int ROOT_W    = 19;   // unsaturated d
    localparam int ACC_W     = 38;   // r*r + x*x, below 2^37
    localparam int PROD_W    = 36;   // 18 x 18 square
    localparam int REM_W     = 20;   // partial remainder of root and divide
    localparam int CU_W      = 22;   // compare/subtract unit width
    localparam int Q_W       = 16;   // quotient bits per divide
    localparam int COS_W     = 16;
    localparam int SIN_W     = 17;
    localparam int COUNT_W   = 4;
    localparam int STEP_W    = 5;

    localparam logic [STEP_W-1:0]  ROOT_LAST = STEP_W'(ROOT_W - 1);
    localparam logic [STEP_W-1:0]  DIV_LAST  = STEP_W'(Q_W - 1);

    localparam logic [COS_W-1:0]   ONE_Q15   = 16'h8000;
    localparam logic [DIAG_W-1:0]  DIAG_MAX  = 18'h3FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_X,
        ST_ROOT,
        ST_DIV_C,
        ST_DIV_S,
        ST_OUT
    } t_gbc_state;

    typedef struct packed {
        logic            ge;
        logic [CU_W-1:0] diff;
    } t_gbc_cmp_res;

endpackage

// ----- hdl/gbc_in_if.sv -----
// Input channel of the Givens boundary cell: valid/ready plus one sample.
// Depends on gbc_pkg.
interface gbc_in_if
    import gbc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

// ----- hdl/gbc_out_if.sv -----
// Result channel of the Givens boundary cell: valid/ready plus rotation and r.
// Depends on gbc_pkg.
interface gbc_out_if
    import gbc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [COS_W-1:0]          cos_value;
    logic signed [SIN_W-1:0]   sin_value;
    logic [DIAG_W-1:0]         diag_value;
    logic                      ignored;

    modport source (output valid, output cos_value, output sin_value,
                    output diag_value, output ignored, input ready);
    modport sink   (input valid, input cos_value, input sin_value,
                    input diag_value, input ignored, output ready);
endinterface

// ----- hdl/gbc_cmp_sub.sv -----
// Shared compare/subtract unit of the Givens boundary cell, used by the
// square root and both divisions. Depends on gbc_pkg.
module gbc_cmp_sub
    import gbc_pkg::*;
(
    input  logic [CU_W-1:0] i_a,
    input  logic [CU_W-1:0] i_b,
    output t_gbc_cmp_res    o_res
);
    logic [CU_W:0] w_sub;

    // Borrow out of the wide subtract gives the compare.
    assign w_sub      = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_sub[CU_W];
    assign o_res.diff = w_sub[CU_W-1:0];
endmodule

// ----- hdl/givens_boundary_cell_core.sv -----
// Top level of the Givens boundary cell: sequencer, registers and the shared
// multiplier; instantiates gbc_cmp_sub. Depends on gbc_pkg, gbc_in_if, gbc_out_if.
//
//  channel   dir  handshake        payload
//  i_x       in   valid / ready    x_value   (signed Q8.8)
//  o_res     out  valid / ready    cos_value, sin_value, diag_value, ignored
//  cfg       in   i_cfg_we only    i_cfg_wdata (start_count, also loads count)
//
// An ignored or zero sample has its result in the cycle after acceptance.
// A processed nonzero sample takes the two squares on the shared squarer, 19 root
// steps and two 16-step divisions on the one compare/subtract unit.
// The cell takes one transaction at a time; ready returns once the result
// is taken. Reset clears r and the count.
module givens_boundary_cell_core
    import gbc_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gbc_in_if.sink               i_x,
    gbc_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_wdata
);

    t_gbc_state r_state, n_state;

    logic [COUNT_W-1:0]  r_count;
    logic [DIAG_W-1:0]   r_diag;
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;
    logic [ACC_W-1:0]    r_acc;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   r_d;
    logic [Q_W-1:0]      r_q;
    logic [STEP_W-1:0]   r_step;
    logic [COS_W-1:0]    r_cos;
    logic [SIN_W-1:0]    r_sin;
    logic                r_ign;

    logic                w_take;
    logic                w_ign_now;
    logic                w_x_neg;
    logic [MAG_W-1:0]    w_x_mag;
    logic [DIAG_W-1:0]   w_mul_op;
    logic [PROD_W-1:0]   w_prod;
    logic [CU_W-1:0]     w_cu_a, w_cu_b;
    t_gbc_cmp_res        w_cu;
    logic [ROOT_W-1:0]   w_root_next;
    logic [Q_W-1:0]      w_q_next;
    logic [SIN_W-1:0]    w_sq_ext;

    // Sample decode: magnitude in 16 unsigned bits (-32768 maps to 32768).
    assign w_x_neg   = i_x.x_value[X_W-1];
    assign w_x_mag   = w_x_neg ? (MAG_W'(0) - MAG_W'(i_x.x_value)) : MAG_W'(i_x.x_value);
    assign w_take    = i_x.valid && i_x.ready;
    assign w_ign_now = (32'(r_count) >= 32'(ROWS));

    // Shared squarer: r*r first, then x*x.
    assign w_mul_op = (r_state == ST_SQ_R) ? r_diag : DIAG_W'(r_mag);
    assign w_prod   = PROD_W'(w_mul_op) * PROD_W'(w_mul_op);

    // Operand select for the shared compare/subtract unit.
    always_comb begin
        case (r_state)
            ST_ROOT: begin
                w_cu_a = {r_rem, r_acc[ACC_W-1 -: 2]};
                w_cu_b = {1'b0, r_root, 2'b01};
            end
            ST_DIV_C, ST_DIV_S: begin
                w_cu_a = CU_W'(r_rem);
                w_cu_b = CU_W'(r_d);
            end
            default: begin
                w_cu_a = '0;
                w_cu_b = '0;
            end
        endcase
    end

    gbc_cmp_sub u_cmp_sub (
        .i_a   (w_cu_a),
        .i_b   (w_cu_b),
        .o_res (w_cu)
    );

    assign w_root_next = {r_root[ROOT_W-2:0], w_cu.ge};
    assign w_q_next    = {r_q[Q_W-2:0], w_cu.ge};
    assign w_sq_ext    = SIN_W'(w_q_next);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (w_ign_now || (w_x_mag == '0)) n_state = ST_OUT;
                    else                              n_state = ST_SQ_R;
                end
            end
            ST_SQ_R:  n_state = ST_SQ_X;
            ST_SQ_X:  n_state = ST_ROOT;
            ST_ROOT:  if (r_step == ROOT_LAST) n_state = ST_DIV_C;
            ST_DIV_C: if (r_step == DIV_LAST)  n_state = ST_DIV_S;
            ST_DIV_S: if (r_step == DIV_LAST)  n_state = ST_OUT;
            ST_OUT:   if (o_res.ready)         n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        i_x.ready   = 1'b0;
        o_res.valid = 1'b0;
        case (r_state)
            ST_IDLE: i_x.ready   = 1'b1;
            ST_OUT:  o_res.valid = 1'b1;
            default: begin
                i_x.ready   = 1'b0;
                o_res.valid = 1'b0;
            end
        endcase
    end

    assign o_res.cos_value  = r_cos;
    assign o_res.sin_value  = r_sin;
    assign o_res.diag_value = r_diag;
    assign o_res.ignored    = r_ign;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_diag  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                // Load start value into the count.
                r_count <= i_cfg_wdata;
            end else if (w_take && !w_ign_now && (r_count != COUNT_MAX)) begin
                r_count <= r_count + COUNT_W'(1);
            end
            case (r_state)
                ST_ROOT, ST_DIV_C: begin
                    if (n_state != r_state) r_step <= '0;
                    else                    r_step <= r_step + STEP_W'(1);
                end
                ST_DIV_S: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == DIV_LAST) begin
                        r_step <= '0;
                        // Saturate the new diagonal.
                        r_diag <= (r_d > ROOT_W'(DIAG_MAX)) ? DIAG_MAX
                                                            : r_d[DIAG_W-1:0];
                    end
                end
                default: r_step <= '0;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_mag <= w_x_mag;
                r_neg <= w_x_neg;
                r_cos <= ONE_Q15;
                r_sin <= '0;
                r_ign <= w_ign_now;
            end
            ST_SQ_R: begin
                r_acc <= ACC_W'(w_prod);
            end
            ST_SQ_X: begin
                r_acc  <= r_acc + ACC_W'(w_prod);
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_ROOT: begin
                // One result bit per step; feed the next two radicand bits.
                r_acc  <= {r_acc[ACC_W-3:0], 2'b00};
                r_root <= w_root_next;
                r_rem  <= w_cu.ge ? w_cu.diff[REM_W-1:0] : w_cu_a[REM_W-1:0];
                if (r_step == ROOT_LAST) begin
                    r_d   <= w_root_next;
                    r_rem <= REM_W'(r_diag);
                    r_q   <= '0;
                end
            end
            ST_DIV_C, ST_DIV_S: begin
                r_q   <= w_q_next;
                r_rem <= w_cu.ge ? {w_cu.diff[REM_W-2:0], 1'b0}
                                 : {r_rem[REM_W-2:0], 1'b0};
                if (r_step == DIV_LAST) begin
                    if (r_state == ST_DIV_C) begin
                        r_cos <= w_q_next;
                        r_rem <= REM_W'(r_mag);
                        r_q   <= '0;
                    end else begin
                        r_sin <= r_neg ? (SIN_W'(0) - w_sq_ext) : w_sq_ext;
                    end
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

endmodule

// ----- bench/givens_boundary_cell_core_tb.sv -----
// Self-checking bench for givens_boundary_cell_core: directed table, then random phases.
// Predicts every rotation in fixed point and checks each result transaction in order.
// Depends on gbc_pkg, gbc_in_if, gbc_out_if and the core itself.
module givens_boundary_cell_core_tb;
    import gbc_pkg::*;

    localparam int ROWS          = 8;
    localparam int SAMPLE_TARGET = 650;   // samples sent before the stimulus stops
    localparam int CALM_FROM     = 570;   // no random idle bursts on either side after this many
    localparam int DRAIN_CYCLES  = 64;    // quiet stretch once every rotation is back
    localparam int N_DIRECTED    = 17;

    // One result transaction as the checker sees it.
    typedef struct packed {
        logic [COS_W-1:0]  cos_value;
        logic [SIN_W-1:0]  sin_value;
        logic [DIAG_W-1:0] diag_value;
        logic              ignored;
    } t_rotation;

    // One row of the directed table: optional start-count load, then one sample.
    typedef struct packed {
        logic               load;
        logic [COUNT_W-1:0] load_val;
        logic [X_W-1:0]     x;
        logic               typed;     // take want as is instead of the prediction
        t_rotation          want;
    } t_step_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    gbc_in_if  x_if ();
    gbc_out_if res_if ();

    givens_boundary_cell_core #(
        .ROWS(ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_x        (x_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Rotation predictor state: running diagonal and processed-sample count.
    bit [DIAG_W-1:0]  diag_q  = '0;
    bit [COUNT_W-1:0] count_q = '0;

    t_rotation rotation_q[$];   // rotations still owed by the cell, oldest first
    int        owed_n      = 0; // mirror of rotation_q.size() that wait() can watch
    int        errors      = 0;
    int        sent_n      = 0;
    bit        calm        = 1'b0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Truncating square root, one bit per pass from the top.
    function automatic bit [ROOT_W-1:0] floor_root(input bit [ACC_W-1:0] v);
        bit [ROOT_W-1:0] root;
        bit [ROOT_W-1:0] trial;
        root = '0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = root | (ROOT_W'(1) << i);
            if (ACC_W'(trial) * ACC_W'(trial) <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Compute the rotation for one sample and advance r and the count.
    function automatic t_rotation predict_rotation(input logic [X_W-1:0] x);
        t_rotation       rot;
        bit              neg;
        bit [MAG_W-1:0]  mag;
        bit [ACC_W-1:0]  acc;
        bit [ROOT_W-1:0] d;
        bit [ACC_W-1:0]  cq;
        bit [ACC_W-1:0]  sq;
        neg = x[X_W-1];
        mag = neg ? MAG_W'(-x) : MAG_W'(x);
        rot.cos_value = ONE_Q15;
        rot.sin_value = '0;
        rot.ignored   = 1'b0;
        if (count_q >= ROWS) begin
            rot.ignored = 1'b1;
        end else begin
            if (mag != 0) begin
                acc = ACC_W'(diag_q) * ACC_W'(diag_q) + ACC_W'(mag) * ACC_W'(mag);
                d   = floor_root(acc);
                // Both quotients use d before saturation.
                cq  = (ACC_W'(diag_q) << 15) / ACC_W'(d);
                sq  = (ACC_W'(mag) << 15) / ACC_W'(d);
                rot.cos_value = cq[COS_W-1:0];
                rot.sin_value = neg ? -sq[SIN_W-1:0] : sq[SIN_W-1:0];
                diag_q = (d > ROOT_W'(DIAG_MAX)) ? DIAG_MAX : d[DIAG_W-1:0];
            end
            if (count_q < COUNT_MAX) begin
                count_q++;
            end
        end
        rot.diag_value = diag_q;
        return rot;
    endfunction

    // Random sample: zeros, the extremes, full-range and small magnitudes.
    function automatic logic [X_W-1:0] pick_sample();
        logic [X_W-1:0] x;
        case ($urandom_range(0, 9))
            0: x = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: x = 16'h8000;
                    1: x = 16'h7FFF;
                    2: x = 16'hFFFF;
                    default: x = 16'h0001;
                endcase
            end
            2, 3, 4, 5: x = X_W'($urandom);
            default: x = X_W'($urandom_range(0, 511) - 256);
        endcase
        return x;
    endfunction

    // Offer one sample, hold it until the cell takes it, then book the rotation.
    task automatic send_sample(input logic [X_W-1:0] x, input bit typed,
                               input t_rotation want);
        t_rotation pred;
        x_if.valid   <= 1'b1;
        x_if.x_value <= x;
        do @(posedge i_clk); while (!x_if.ready);
        pred = predict_rotation(x);
        rotation_q.push_back(typed ? want : pred);
        owed_n++;
        sent_n++;
        // Drop valid for a burst now and then; otherwise keep it up for the next one.
        if (!calm && $urandom_range(0, 3) == 0) begin
            x_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Load start_count only once the cell has handed back every rotation.
    task automatic load_start_count(input logic [COUNT_W-1:0] v);
        x_if.valid <= 1'b0;
        wait (owed_n == 0);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        count_q      = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Directed table: reset state, field extremes, zero samples, the count limit,
    // start values at and beyond the limit.
    t_step_row directed [N_DIRECTED] = '{
        // load 0 right after reset; zero sample is the identity with r still 0
        '{1'b1, 4'd0,  16'h0000, 1'b1, '{16'h8000, 17'h00000, 18'd0,     1'b0}},
        // x = 1.0 against r = 0: pure sine, r becomes 1.0
        '{1'b0, 4'd0,  16'h0100, 1'b1, '{16'd0,    17'h08000, 18'd256,   1'b0}},
        // most negative sample against r = 1.0
        '{1'b0, 4'd0,  16'h8000, 1'b1, '{16'd256,  17'h18000, 18'd32768, 1'b0}},
        '{1'b0, 4'd0,  16'h7FFF, 1'b0, '0},
        '{1'b0, 4'd0,  16'hFFFF, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0001, 1'b0, '0},
        // zero sample with r nonzero: r kept, count advances
        '{1'b0, 4'd0,  16'h0000, 1'b0, '0},
        '{1'b0, 4'd0,  16'h5A5A, 1'b0, '0},
        // count has reached ROWS: these are ignored
        '{1'b0, 4'd0,  16'hA5A5, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0000, 1'b0, '0},
        // start at the limit and at the register maximum
        '{1'b1, 4'd8,  16'h0100, 1'b0, '0},
        '{1'b1, 4'd15, 16'h8000, 1'b0, '0},
        // one slot left, then ignored again
        '{1'b1, 4'd7,  16'h8001, 1'b0, '0},
        '{1'b0, 4'd0,  16'h7FFF, 1'b0, '0},
        '{1'b1, 4'd0,  16'h0080, 1'b0, '0},
        '{1'b0, 4'd0,  16'hFF80, 1'b0, '0},
        '{1'b0, 4'd0,  16'h0000, 1'b0, '0}
    };

    // Stimulus: reset, the directed table, then random phases of start count + samples.
    initial begin
        int start_v;
        int len;
        x_if.valid   <= 1'b0;
        x_if.x_value <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed[i].load) begin
                load_start_count(directed[i].load_val);
            end
            send_sample(directed[i].x, directed[i].typed, directed[i].want);
        end

        // Most phases fill the rows with random samples; a few start at or past
        // the limit, and some run a couple of samples past it.
        while (sent_n < SAMPLE_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: start_v = $urandom_range(0, 3);
                6, 7:             start_v = $urandom_range(4, 7);
                8:                start_v = ROWS;
                default:          start_v = $urandom_range(ROWS + 1, 15);
            endcase
            if (start_v >= ROWS) begin
                len = $urandom_range(1, 3);
            end else if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, ROWS - start_v);
            end else begin
                len = ROWS - start_v + $urandom_range(0, 2);
            end
            load_start_count(COUNT_W'(start_v));
            for (int k = 0; k < len; k++) begin
                if (sent_n >= CALM_FROM) begin
                    calm = 1'b1;
                end
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        // Drain: every rotation back, then a quiet stretch to catch extras.
        x_if.valid <= 1'b0;
        wait (owed_n == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS givens_boundary_cell_core");
        end else begin
            $display("FAIL givens_boundary_cell_core");
        end
        $finish;
    end

    // Receiver: stall in random bursts, none once the run has gone calm.
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0 && !calm) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 16);
                end
            end
        end
    end

    // Checker: each result transaction against the oldest owed rotation.
    always @(posedge i_clk) begin
        t_rotation want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (owed_n == 0) begin
                $display("%0t extra result: expected none, actual %0d %0d %0d %0d",
                         $time, res_if.cos_value, res_if.sin_value, res_if.diag_value,
                         res_if.ignored);
                errors++;
            end else begin
                want = rotation_q.pop_front();
                owed_n--;
                if (res_if.cos_value !== want.cos_value) begin
                    $display("%0t cos_value mismatch: expected %0d, actual %0d",
                             $time, want.cos_value, res_if.cos_value);
                    errors++;
                end
                if (res_if.sin_value !== want.sin_value) begin
                    $display("%0t sin_value mismatch: expected %h, actual %h",
                             $time, want.sin_value, res_if.sin_value);
                    errors++;
                end
                if (res_if.diag_value !== want.diag_value) begin
                    $display("%0t diag_value mismatch: expected %0d, actual %0d",
                             $time, want.diag_value, res_if.diag_value);
                    errors++;
                end
                if (res_if.ignored !== want.ignored) begin
                    $display("%0t ignored mismatch: expected %0d, actual %0d",
                             $time, want.ignored, res_if.ignored);
                    errors++;
                end
            end
        end
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #1000000;
        $display("FAIL givens_boundary_cell_core");
        $finish;
    end

endmodule
